// ===== design/bzev_pkg.sv =====
// Shared types and codes for the cubic Bezier evaluator.
package bzev_pkg;

  // Configuration register indexes, one per control point.
  typedef enum logic [1:0] {
    CFG_START_POINT  = 2'd0,
    CFG_START_HANDLE = 2'd1,
    CFG_END_HANDLE   = 2'd2,
    CFG_END_POINT    = 2'd3
  } cfg_index_t;

  // Per-stage load enables of the evaluation pipeline.
  typedef struct packed {
    logic adv_a;
    logic adv_b;
    logic adv_c;
    logic adv_d;
  } stage_ctl_t;

endpackage

// ===== design/bzev_coef.sv =====
// Power-basis coefficients of one axis, derived from the four control points.
module bzev_coef #(
  parameter int COORD_WIDTH = 16,
  parameter int REG_W       = 48,
  parameter int AXIS        = 0
) (
  input  logic [REG_W-1:0]              p0_reg,
  input  logic [REG_W-1:0]              p1_reg,
  input  logic [REG_W-1:0]              p2_reg,
  input  logic [REG_W-1:0]              p3_reg,
  output logic signed [COORD_WIDTH+3:0] k0,
  output logic signed [COORD_WIDTH+3:0] k1,
  output logic signed [COORD_WIDTH+3:0] k2,
  output logic signed [COORD_WIDTH+3:0] k3
);

  localparam int C  = COORD_WIDTH;
  localparam int PW = 3 * C;
  localparam int KW = C + 4;

  logic [PW-1:0]       p0_pad, p1_pad, p2_pad, p3_pad;
  logic signed [C-1:0] a, b, c, d;
  logic signed [KW-1:0] a_e, b_e, c_e, d_e;
  logic signed [KW-1:0] dba, s2, dbc;

  // Register bits beyond the stored width read as zero.
  assign p0_pad = PW'(p0_reg);
  assign p1_pad = PW'(p1_reg);
  assign p2_pad = PW'(p2_reg);
  assign p3_pad = PW'(p3_reg);

  assign a = p0_pad[AXIS*C +: C];
  assign b = p1_pad[AXIS*C +: C];
  assign c = p2_pad[AXIS*C +: C];
  assign d = p3_pad[AXIS*C +: C];

  assign a_e = KW'(a);
  assign b_e = KW'(b);
  assign c_e = KW'(c);
  assign d_e = KW'(d);

  assign dba = b_e - a_e;
  assign s2  = a_e - (b_e <<< 1) + c_e;
  assign dbc = b_e - c_e;

  assign k0 = a_e;
  assign k1 = dba + (dba <<< 1);
  assign k2 = s2 + (s2 <<< 1);
  assign k3 = d_e - a_e + dbc + (dbc <<< 1);

endmodule

// ===== design/bzev_round_sat.sv =====
// Round-half-up scaling by a power of two followed by saturation.
module bzev_round_sat #(
  parameter int IW    = 40,
  parameter int SHIFT = 16,
  parameter int OW    = 16
) (
  input  logic signed [IW-1:0] din,
  output logic [OW-1:0]        dout
);

  localparam int QW = IW + 1 - SHIFT;
  localparam logic [IW:0] HALF = {{(IW + 1 - SHIFT){1'b0}}, 1'b1, {(SHIFT - 1){1'b0}}};

  logic [IW:0]   biased;
  logic [QW-1:0] q;
  logic [QW-OW:0] top_bits;
  logic          ovf;

  // One guard bit keeps the biased sum from wrapping.
  assign biased   = {din[IW-1], din} + HALF;
  assign q        = biased[IW:SHIFT];
  assign top_bits = q[QW-1:OW-1];
  assign ovf      = !((&top_bits) || !(|top_bits));
  assign dout     = ovf ? {q[QW-1], {(OW - 1){~q[QW-1]}}} : q[OW-1:0];

endmodule

// ===== design/bzev_axis.sv =====
// Four-stage Horner datapath for one axis: position, first and second derivative.
module bzev_axis #(
  parameter int COORD_WIDTH     = 16,
  parameter int PARAM_FRAC_BITS = 16,
  parameter int REG_W           = 48,
  parameter int AXIS            = 0
) (
  input  logic                          clk,
  input  bzev_pkg::stage_ctl_t          ctl,
  input  logic [REG_W-1:0]              p0_reg,
  input  logic [REG_W-1:0]              p1_reg,
  input  logic [REG_W-1:0]              p2_reg,
  input  logic [REG_W-1:0]              p3_reg,
  input  logic [PARAM_FRAC_BITS:0]      t_in,
  input  logic [PARAM_FRAC_BITS:0]      t_a,
  input  logic [PARAM_FRAC_BITS:0]      t_b,
  output logic signed [COORD_WIDTH-1:0] pos,
  output logic signed [COORD_WIDTH+2:0] vel,
  output logic signed [COORD_WIDTH+4:0] acc
);
  import bzev_pkg::*;

  localparam int C  = COORD_WIDTH;
  localparam int F  = PARAM_FRAC_BITS;
  localparam int TW = F + 1;
  localparam int KW = C + 4;
  localparam int MW = KW + TW;
  localparam int W1 = C + F + 7;
  localparam int W2 = W1 + TW;
  localparam int W3 = W2 + TW;

  logic signed [KW-1:0] k0, k1, k2, k3;

  // Stage A: leading product k3 * t.
  logic signed [MW-1:0] m_a;
  // Stage B: partial Horner sums and the finished second derivative.
  logic signed [W1-1:0] mx, p1, v1, a1;
  logic signed [W2-1:0] p2, v2, p2_b, v2_b;
  logic [C+4:0]         acc_r, acc_b;
  // Stage C: full position sum and the finished first derivative.
  logic signed [W3-1:0] p3, p3_c;
  logic [C+2:0]         vel_r, vel_c;
  logic [C+4:0]         acc_c;
  // Stage D: finished position.
  logic [C-1:0]         pos_r;

  bzev_coef #(
    .COORD_WIDTH (C),
    .REG_W       (REG_W),
    .AXIS        (AXIS)
  ) u_coef (
    .p0_reg (p0_reg),
    .p1_reg (p1_reg),
    .p2_reg (p2_reg),
    .p3_reg (p3_reg),
    .k0     (k0),
    .k1     (k1),
    .k2     (k2),
    .k3     (k3)
  );

  always_ff @(posedge clk) begin
    if (ctl.adv_a) begin
      m_a <= k3 * $signed({1'b0, t_in});
    end
  end

  assign mx = W1'(m_a);
  assign p1 = mx + (W1'(k2) <<< F);
  assign v1 = mx + (mx <<< 1) + (W1'(k2) <<< (F + 1));
  assign a1 = (mx <<< 1) + (mx <<< 2) + (W1'(k2) <<< (F + 1));
  assign p2 = p1 * $signed({1'b0, t_a}) + (W2'(k1) <<< (2 * F));
  assign v2 = v1 * $signed({1'b0, t_a}) + (W2'(k1) <<< (2 * F));

  bzev_round_sat #(.IW(W1), .SHIFT(F), .OW(C + 5)) u_rs_acc (
    .din  (a1),
    .dout (acc_r)
  );

  always_ff @(posedge clk) begin
    if (ctl.adv_b) begin
      p2_b  <= p2;
      v2_b  <= v2;
      acc_b <= acc_r;
    end
  end

  assign p3 = p2_b * $signed({1'b0, t_b}) + (W3'(k0) <<< (3 * F));

  bzev_round_sat #(.IW(W2), .SHIFT(2 * F), .OW(C + 3)) u_rs_vel (
    .din  (v2_b),
    .dout (vel_r)
  );

  always_ff @(posedge clk) begin
    if (ctl.adv_c) begin
      p3_c  <= p3;
      vel_c <= vel_r;
      acc_c <= acc_b;
    end
  end

  bzev_round_sat #(.IW(W3), .SHIFT(3 * F), .OW(C)) u_rs_pos (
    .din  (p3_c),
    .dout (pos_r)
  );

  always_ff @(posedge clk) begin
    if (ctl.adv_d) begin
      pos <= pos_r;
      vel <= vel_c;
      acc <= acc_c;
    end
  end

endmodule

// ===== design/cubic_bezier_evaluator_top.sv =====
// Top level of the cubic Bezier evaluator: control points, pipeline control and axes.
// A beat accepted at the input passes through four register stages (t * k3, two Horner steps,
// rounding) and is then shown on the outputs.
// Throughput: one beat per cycle; a stage holds only while the stage after it is full
// and stalled, so input is refused only when all four stages hold beats and the output stalls.
// Reset clears all stage valid bits and the control points, and holds in_ready low.
module cubic_bezier_evaluator_top #(
  parameter int COORD_WIDTH     = 16,
  parameter int PARAM_FRAC_BITS = 16,
  localparam int REG_W          = (3 * COORD_WIDTH > 64) ? 64 : 3 * COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port.
  input  logic                          cfg_wr_en,
  input  bzev_pkg::cfg_index_t          cfg_addr,
  input  logic [REG_W-1:0]              cfg_wdata,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [PARAM_FRAC_BITS:0]      curve_param,
  // Output channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] pos_x,
  output logic signed [COORD_WIDTH-1:0] pos_y,
  output logic signed [COORD_WIDTH-1:0] pos_z,
  output logic signed [COORD_WIDTH+2:0] vel_x,
  output logic signed [COORD_WIDTH+2:0] vel_y,
  output logic signed [COORD_WIDTH+2:0] vel_z,
  output logic signed [COORD_WIDTH+4:0] acc_x,
  output logic signed [COORD_WIDTH+4:0] acc_y,
  output logic signed [COORD_WIDTH+4:0] acc_z
);
  import bzev_pkg::*;

  localparam int F = PARAM_FRAC_BITS;

  // Control points. The user must change them only while the pipeline is empty, which the block
  // does not enforce; then every stage can read the coefficients straight from these registers.
  logic [REG_W-1:0] start_point;
  logic [REG_W-1:0] start_handle;
  logic [REG_W-1:0] end_handle;
  logic [REG_W-1:0] end_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_point  <= '0;
      start_handle <= '0;
      end_handle   <= '0;
      end_point    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_START_POINT:  start_point  <= cfg_wdata;
        CFG_START_HANDLE: start_handle <= cfg_wdata;
        CFG_END_HANDLE:   end_handle   <= cfg_wdata;
        CFG_END_POINT:    end_point    <= cfg_wdata;
        default:          start_point  <= start_point;
      endcase
    end
  end

  // Pipeline control. Each stage loads when it is empty or when its content
  // moves on, so a stall at the output backs up one stage at a time and no
  // beat is dropped or duplicated.
  logic       valid_a, valid_b, valid_c, valid_d;
  stage_ctl_t ctl;

  assign ctl.adv_d = !valid_d || out_ready;
  assign ctl.adv_c = !valid_c || ctl.adv_d;
  assign ctl.adv_b = !valid_b || ctl.adv_c;
  assign ctl.adv_a = !valid_a || ctl.adv_b;

  // No beat is taken while reset is applied.
  assign in_ready  = ctl.adv_a && !rst;
  assign out_valid = valid_d && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
      valid_d <= 1'b0;
    end else begin
      if (ctl.adv_a) valid_a <= in_valid;
      if (ctl.adv_b) valid_b <= valid_a;
      if (ctl.adv_c) valid_c <= valid_b;
      if (ctl.adv_d) valid_d <= valid_c;
    end
  end

  // A parameter above one is clamped to exactly one. Any value with the
  // integer bit set is at least one, so the clamp only needs that bit.
  logic [F:0] t_clamp, t_a, t_b;

  assign t_clamp = curve_param[F] ? {1'b1, {F{1'b0}}} : curve_param;

  always_ff @(posedge clk) begin
    if (ctl.adv_a) t_a <= t_clamp;
    if (ctl.adv_b) t_b <= t_a;
  end

  bzev_axis #(
    .COORD_WIDTH     (COORD_WIDTH),
    .PARAM_FRAC_BITS (F),
    .REG_W           (REG_W),
    .AXIS            (0)
  ) u_axis_x (
    .clk    (clk),
    .ctl    (ctl),
    .p0_reg (start_point),
    .p1_reg (start_handle),
    .p2_reg (end_handle),
    .p3_reg (end_point),
    .t_in   (t_clamp),
    .t_a    (t_a),
    .t_b    (t_b),
    .pos    (pos_x),
    .vel    (vel_x),
    .acc    (acc_x)
  );

  bzev_axis #(
    .COORD_WIDTH     (COORD_WIDTH),
    .PARAM_FRAC_BITS (F),
    .REG_W           (REG_W),
    .AXIS            (1)
  ) u_axis_y (
    .clk    (clk),
    .ctl    (ctl),
    .p0_reg (start_point),
    .p1_reg (start_handle),
    .p2_reg (end_handle),
    .p3_reg (end_point),
    .t_in   (t_clamp),
    .t_a    (t_a),
    .t_b    (t_b),
    .pos    (pos_y),
    .vel    (vel_y),
    .acc    (acc_y)
  );

  bzev_axis #(
    .COORD_WIDTH     (COORD_WIDTH),
    .PARAM_FRAC_BITS (F),
    .REG_W           (REG_W),
    .AXIS            (2)
  ) u_axis_z (
    .clk    (clk),
    .ctl    (ctl),
    .p0_reg (start_point),
    .p1_reg (start_handle),
    .p2_reg (end_handle),
    .p3_reg (end_point),
    .t_in   (t_clamp),
    .t_a    (t_a),
    .t_b    (t_b),
    .pos    (pos_z),
    .vel    (vel_z),
    .acc    (acc_z)
  );

endmodule

// ===== verif/tb_cubic_bezier_evaluator_top.sv =====
// Self-checking testbench for the cubic Bezier evaluator: directed table, then random phases.
module tb_cubic_bezier_evaluator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bzev_pkg::*;

  localparam int CW              = 16;
  localparam int FRAC            = 16;
  localparam int PT_W            = 3 * CW;
  localparam logic [FRAC:0] T_ONE = 17'h10000;
  localparam int RAND_PHASES     = 8;
  localparam int BEATS_PER_PHASE = 100;
  // The settle time covers the four register stages given in the header of the top level.
  localparam int PIPE_SETTLE     = 6;
  localparam int HOLD_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 250000;
  localparam int MAX_REPORTS     = 10;

  // One result beat: position, first and second derivative on all three axes.
  typedef struct packed {
    logic signed [CW-1:0] pos_x, pos_y, pos_z;
    logic signed [CW+2:0] vel_x, vel_y, vel_z;
    logic signed [CW+4:0] acc_x, acc_y, acc_z;
  } kin_t;

  typedef enum {ROW_WRITE, ROW_BEAT} row_kind_t;

  // How the two sides of the block pause during a phase.
  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // One row of the directed table. A row with a typed result carries it in want; any other
  // beat row is checked against the curve predictor.
  typedef struct {
    row_kind_t         kind;
    cfg_index_t        idx;
    logic [PT_W-1:0]   data;
    logic [FRAC:0]     t;
    bit                typed;
    kin_t              want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  cfg_index_t cfg_addr = CFG_START_POINT;
  logic [PT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FRAC:0] curve_param = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] pos_x, pos_y, pos_z;
  logic signed [CW+2:0] vel_x, vel_y, vel_z;
  logic signed [CW+4:0] acc_x, acc_y, acc_z;

  // Testbench copy of the four control points, updated as each register is written.
  logic [PT_W-1:0] ctrl_pts [4] = '{default: '0};

  kin_t      kin_q [$];
  stim_row_t plan [$];

  int mismatches    = 0;
  int results_seen  = 0;
  int beats_sent    = 0;
  int regs_written  = 0;
  int stall_cycles  = 0;
  int cycles        = 0;
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int holds_asked   = 0;
  int holds_done    = 0;
  int hold_left     = 0;

  cubic_bezier_evaluator_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .curve_param (curve_param),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .vel_x       (vel_x),
    .vel_y       (vel_y),
    .vel_z       (vel_z),
    .acc_x       (acc_x),
    .acc_y       (acc_y),
    .acc_z       (acc_z)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Evaluates c0 + c1 t + ... at degree deg with t = tv / 2^FRAC. The sum is kept exact at
  // scale 2^(FRAC*deg) in 128 bits, then half an output step is added and the floor taken,
  // so exact halves go toward plus infinity.
  function automatic logic signed [127:0] horner_round(input logic signed [63:0] c0, c1, c2, c3,
                                                       input int deg, input logic [FRAC:0] tv);
    logic signed [63:0]  c [4];
    logic signed [127:0] sum, term, tw;
    int i;
    c[0] = c0;
    c[1] = c1;
    c[2] = c2;
    c[3] = c3;
    tw = tv;
    sum = c[deg];
    for (i = deg - 1; i >= 0; i--) begin
      term = c[i];
      term = term <<< (FRAC * (deg - i));
      sum = sum * tw + term;
    end
    sum = sum + (128'sd1 <<< (FRAC * deg - 1));
    return sum >>> (FRAC * deg);
  endfunction

  // Saturates to a signed field of w bits.
  function automatic logic signed [63:0] clip(input logic signed [127:0] v, input int w);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (w - 1)) - 128'sd1;
    lo = -hi - 128'sd1;
    if (v > hi) v = hi;
    else if (v < lo) v = lo;
    return v[63:0];
  endfunction

  // Expected result for one parameter beat under the current control points.
  function automatic kin_t eval_curve(input logic [FRAC:0] t_raw);
    logic [FRAC:0] tv;
    logic signed [63:0] a, b, c, d, k1, k2, k3;
    logic signed [63:0] p [3], v [3], q [3];
    kin_t r;
    int axis;
    // A parameter above one is treated as exactly one.
    tv = (t_raw > T_ONE) ? T_ONE : t_raw;
    for (axis = 0; axis < 3; axis++) begin
      a = $signed(ctrl_pts[0][CW*axis +: CW]);
      b = $signed(ctrl_pts[1][CW*axis +: CW]);
      c = $signed(ctrl_pts[2][CW*axis +: CW]);
      d = $signed(ctrl_pts[3][CW*axis +: CW]);
      // Power-basis coefficients of the segment on this axis.
      k1 = 3 * (b - a);
      k2 = 3 * (a - 2 * b + c);
      k3 = d - a + 3 * (b - c);
      p[axis] = clip(horner_round(a, k1, k2, k3, 3, tv), CW);
      v[axis] = clip(horner_round(k1, 2 * k2, 3 * k3, 0, 2, tv), CW + 3);
      q[axis] = clip(horner_round(2 * k2, 6 * k3, 0, 0, 1, tv), CW + 5);
    end
    r.pos_x = p[0][CW-1:0];
    r.pos_y = p[1][CW-1:0];
    r.pos_z = p[2][CW-1:0];
    r.vel_x = v[0][CW+2:0];
    r.vel_y = v[1][CW+2:0];
    r.vel_z = v[2][CW+2:0];
    r.acc_x = q[0][CW+4:0];
    r.acc_y = q[1][CW+4:0];
    r.acc_z = q[2][CW+4:0];
    return r;
  endfunction

  // Builds a result from plain integers for the rows whose outcome is typed in.
  function automatic kin_t kin(input int px, py, pz, vx, vy, vz, qx, qy, qz);
    kin_t r;
    r.pos_x = px[CW-1:0];
    r.pos_y = py[CW-1:0];
    r.pos_z = pz[CW-1:0];
    r.vel_x = vx[CW+2:0];
    r.vel_y = vy[CW+2:0];
    r.vel_z = vz[CW+2:0];
    r.acc_x = qx[CW+4:0];
    r.acc_y = qy[CW+4:0];
    r.acc_z = qz[CW+4:0];
    return r;
  endfunction

  function automatic void add_write(input cfg_index_t idx, input logic [PT_W-1:0] data);
    stim_row_t r;
    r = '{ROW_WRITE, idx, data, '0, 1'b0, '0};
    plan.push_back(r);
  endfunction

  function automatic void add_beat(input logic [FRAC:0] t, input bit typed, input kin_t want);
    stim_row_t r;
    r = '{ROW_BEAT, CFG_START_POINT, '0, t, typed, want};
    plan.push_back(r);
  endfunction

  // Coordinates lean toward the extremes and toward small values near the origin.
  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return '0;
      3: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [PT_W-1:0] rand_point();
    return {rand_coord(), rand_coord(), rand_coord()};
  endfunction

  // Mostly t inside the segment, with the ends, values near them and values above one.
  function automatic logic [FRAC:0] rand_param();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return T_ONE;
      2: return 17'($urandom_range(32'h10001, 32'h1FFFF));
      3: return 17'($urandom_range(0, 15));
      4: return T_ONE - 17'($urandom_range(0, 15));
      default: return 17'($urandom_range(0, 32'hFFFF));
    endcase
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    src_idle_pct   = (mode == IDLE_SENDER)   ? 62 : (mode == IDLE_BOTH) ? 17 : 0;
    sink_stall_pct = (mode == IDLE_RECEIVER) ? 62 : (mode == IDLE_BOTH) ? 17 : 0;
  endtask

  // Offers one parameter beat, with random idle cycles ahead of it, and records the expected
  // result at the edge where the beat is taken.
  task automatic send_beat(input logic [FRAC:0] t, input bit typed, input kin_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    curve_param <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    kin_q.push_back(typed ? want : eval_curve(t));
    beats_sent++;
  endtask

  // Control points change only with the pipeline empty: every expected result has arrived and
  // the stages have had time to settle.
  task automatic write_reg(input cfg_index_t idx, input logic [PT_W-1:0] data);
    in_valid <= 1'b0;
    while (kin_q.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ctrl_pts[idx] = data;
    regs_written++;
  endtask

  task automatic note_field(input string name, input longint want, input longint got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("result %0d, %s: expected %0d, got %0d", results_seen, name, want, got);
  endtask

  // Compares one result beat with the oldest expectation, field by field.
  task automatic check_result();
    kin_t want;
    if (kin_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d arrived with no parameter beat waiting for it", results_seen);
    end else begin
      want = kin_q.pop_front();
      if (pos_x !== want.pos_x) note_field("pos_x", want.pos_x, pos_x);
      if (pos_y !== want.pos_y) note_field("pos_y", want.pos_y, pos_y);
      if (pos_z !== want.pos_z) note_field("pos_z", want.pos_z, pos_z);
      if (vel_x !== want.vel_x) note_field("vel_x", want.vel_x, vel_x);
      if (vel_y !== want.vel_y) note_field("vel_y", want.vel_y, vel_y);
      if (vel_z !== want.vel_z) note_field("vel_z", want.vel_z, vel_z);
      if (acc_x !== want.acc_x) note_field("acc_x", want.acc_x, acc_x);
      if (acc_y !== want.acc_y) note_field("acc_y", want.acc_y, acc_y);
      if (acc_z !== want.acc_z) note_field("acc_z", want.acc_z, acc_z);
    end
    results_seen++;
  endtask

  // Receiver. Values are sampled at the edge before any update of that edge lands, so a beat
  // counts when valid and ready were both high going into it. A hold request from the main
  // sequence is turned into a long run of low ready, counted down here.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
    if (!rst && in_valid && !in_ready) stall_cycles++;
    if (holds_asked != holds_done) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, kin_q.size());
      $display("cubic_bezier_evaluator_top: mismatch");
      $finish;
    end
  end

  initial begin
    kin_t at_one;
    logic [PT_W-1:0] pts [4];
    int ph, n, i;

    // Alternating extreme control points; at t = 1 the curve sits on the end point and the
    // derivatives come from the last three points.
    at_one = kin(-32768, 32767, 256, -196605, 196605, 768, -786420, 786420, 1536);

    // After reset every control point is at the origin, so every field is zero, also for a
    // parameter above one.
    add_beat(17'h00000, 1'b1, '0);
    add_beat(17'h10000, 1'b1, '0);
    add_beat(17'h1FFFF, 1'b1, '0);

    // Lines x = 3t and y = -3t, and the cubic z = t^3. At t = 1/2 the x and y positions are
    // exactly +1.5 and -1.5; at t = 1/4 the z second derivative is exactly 1.5. Ties round up.
    add_write(CFG_START_POINT,  48'h0000_0000_0000);
    add_write(CFG_START_HANDLE, 48'h0000_FFFF_0001);
    add_write(CFG_END_HANDLE,   48'h0000_FFFE_0002);
    add_write(CFG_END_POINT,    48'h0001_FFFD_0003);
    add_beat(17'h08000, 1'b1, kin(2, -1, 0, 3, -3, 1, 0, 0, 3));
    add_beat(17'h04000, 1'b1, kin(1, -1, 0, 3, -3, 0, 0, 0, 2));

    // Control points swinging between the most positive and most negative coordinate: the
    // derivatives reach their largest possible magnitudes at both ends of the segment.
    add_write(CFG_START_POINT,  48'h0000_8000_7FFF);
    add_write(CFG_START_HANDLE, 48'h0000_7FFF_8000);
    add_write(CFG_END_HANDLE,   48'h0000_8000_7FFF);
    add_write(CFG_END_POINT,    48'h0100_7FFF_8000);
    add_beat(17'h00000, 1'b1,
             kin(32767, -32768, 0, -196605, 196605, 0, 786420, -786420, 0));
    add_beat(17'h10000, 1'b1, at_one);
    add_beat(17'h10001, 1'b1, at_one);
    add_beat(17'h1FFFF, 1'b1, at_one);
    add_beat(17'h08000, 1'b0, '0);
    add_beat(17'h00001, 1'b0, '0);
    add_beat(17'h0FFFF, 1'b0, '0);
    add_beat(17'h0AAAA, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    set_idle(IDLE_BOTH);
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        send_beat(plan[r].t, plan[r].typed, plan[r].want);
      end
    end

    // Random phases. Each one loads a new segment while the pipeline is empty, then streams
    // parameter beats under one idling pattern. The fifth phase also holds the receiver off
    // for a long stretch while the sender keeps offering, so the pipeline fills and stalls.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          pts[0] = 48'h7FFF_8000_7FFF;
          pts[1] = 48'h8000_7FFF_8000;
          pts[2] = 48'h7FFF_8000_7FFF;
          pts[3] = 48'h8000_7FFF_8000;
        end
        1: begin
          pts[0] = 48'h8000_8000_8000;
          pts[1] = 48'h7FFF_7FFF_7FFF;
          pts[2] = 48'h7FFF_7FFF_7FFF;
          pts[3] = 48'h8000_8000_8000;
        end
        default: begin
          for (i = 0; i < 4; i++) pts[i] = rand_point();
        end
      endcase
      for (i = 0; i < 4; i++) write_reg(cfg_index_t'(i), pts[i]);
      set_idle(idle_mode_t'(ph % 4));
      if (ph == 4) holds_asked++;
      for (n = 0; n < BEATS_PER_PHASE; n++) send_beat(rand_param(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (kin_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d parameter beats across %0d control point writes; checked %0d results.",
             beats_sent, regs_written, results_seen);
    $display("Input held off by back-pressure on %0d cycles; %0d field mismatches.",
             stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("cubic_bezier_evaluator_top: match");
    end else begin
      $display("cubic_bezier_evaluator_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== cubic_bezier_evaluator_top.f =====
design/bzev_pkg.sv
design/bzev_coef.sv
design/bzev_round_sat.sv
design/bzev_axis.sv
design/cubic_bezier_evaluator_top.sv
verif/tb_cubic_bezier_evaluator_top.sv
